/* src/jise_pkg.sv */
// Package: opcodes, status codes and default sizes for the integer stack executor.
`default_nettype none
package jise_pkg;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int LOCAL_COUNT_DEF = 256;

    localparam logic [7:0] OP_BIPUSH = 8'h10;
    localparam logic [7:0] OP_ILOAD  = 8'h15;
    localparam logic [7:0] OP_ISTORE = 8'h36;
    localparam logic [7:0] OP_DUP    = 8'h59;
    localparam logic [7:0] OP_IADD   = 8'h60;
    localparam logic [7:0] OP_ISUB   = 8'h64;
    localparam logic [7:0] OP_IMUL   = 8'h68;
    localparam logic [7:0] OP_IDIV   = 8'h6C;
    localparam logic [7:0] OP_IREM   = 8'h70;
    localparam logic [7:0] OP_INEG   = 8'h74;
    localparam logic [7:0] OP_IAND   = 8'h7E;
    localparam logic [7:0] OP_IOR    = 8'h80;
    localparam logic [7:0] OP_IXOR   = 8'h82;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_ILL   = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_OVER  = 3'd3;
    localparam logic [2:0] ST_DIVZ  = 3'd4;
    localparam logic [2:0] ST_INDEX = 3'd5;
endpackage
`default_nettype wire

/* src/jvm_int_stack_executor.sv */
// Top level: sequenced integer bytecode executor with shared serial divider.
//
// channel | signals                               | dir
// in      | in_valid in_ready opcode operand_byte | in
// out     | out_valid out_ready status top_value  | out
//         | stack_count                           |
//
// Simple opcodes step through stack RAM read, execute, write and top read.
// idiv/irem use a 32-step restoring divider, one quotient bit a cycle.
// Reset clears the stack pointer, then a clearing pass over all LOCAL_COUNT
// entries zeroes the locals memory before the first transfer is taken.
// The block holds in_ready low from a transfer until its result is taken.
`default_nettype none
module jvm_int_stack_executor
    import jise_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int LOCAL_COUNT = LOCAL_COUNT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         opcode,
    input  wire logic [7:0]         operand_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              status,
    output logic signed [31:0]      top_value,
    output logic [6:0]              stack_count
);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LAW = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_EXEC = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_WR   = 4'd6;
    localparam logic [3:0] S_TOP  = 4'd7;
    localparam logic [3:0] S_TOP2 = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] local_mem [LOCAL_COUNT];

    logic [3:0]     state_reg;
    logic [SPW-1:0] sp_reg;
    logic [LAW:0]   clr_reg;
    logic [7:0]     op_reg, arg_reg;
    logic [31:0]    a_reg, res_reg, srd_reg, lrd_reg;
    logic [2:0]     st_reg;
    logic [5:0]     cnt_reg;
    logic [31:0]    quo_reg, rem_reg, dvd_reg, dvs_reg;
    logic           qneg_reg, rneg_reg;

    logic [SAW-1:0] s_raddr, s_waddr;
    logic           s_we, l_we;
    logic [31:0]    s_wdata;
    logic [LAW-1:0] l_addr;
    logic [31:0]    l_wdata;
    logic [32:0]    trial;
    logic           idx_bad, binop;

    assign idx_bad = {24'd0, arg_reg} >= 32'(LOCAL_COUNT);
    always_comb
    begin
        case (op_reg)
            OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV,
            OP_IREM, OP_IAND, OP_IOR, OP_IXOR: binop = 1'b1;
            default: binop = 1'b0;
        endcase
    end

    assign trial = {rem_reg, dvd_reg[31]} - {1'b0, dvs_reg};

    always_comb
    begin
        s_raddr = SAW'(sp_reg - SPW'(1));
        if (state_reg == S_RD1 && binop)
            s_raddr = SAW'(sp_reg - SPW'(2));
        s_we    = 1'b0;
        s_waddr = SAW'(sp_reg);
        s_wdata = res_reg;
        l_we    = 1'b0;
        l_addr  = LAW'(arg_reg);
        l_wdata = srd_reg;
        if (state_reg == S_CLR)
        begin
            l_we    = 1'b1;
            l_addr  = LAW'(clr_reg);
            l_wdata = '0;
        end
        else if (state_reg == S_WR && st_reg == ST_OK)
        begin
            if (op_reg == OP_ISTORE)
                l_we = 1'b1;
            else
            begin
                s_we = 1'b1;
                if (op_reg == OP_INEG)
                    s_waddr = SAW'(sp_reg - SPW'(1));
                else if (binop)
                    s_waddr = SAW'(sp_reg - SPW'(2));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            stack_mem[s_waddr] <= s_wdata;
        srd_reg <= stack_mem[s_raddr];
        if (l_we)
            local_mem[l_addr] <= l_wdata;
        lrd_reg <= local_mem[l_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            sp_reg    <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (LAW+1)'(LOCAL_COUNT - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= opcode;
                        arg_reg   <= operand_byte;
                        state_reg <= S_RD1;
                    end
                end
                S_RD1:
                    state_reg <= binop ? S_RD2 : S_EXEC;
                S_RD2:
                begin
                    a_reg     <= srd_reg;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    st_reg    <= ST_OK;
                    state_reg <= S_WR;
                    case (op_reg)
                        OP_ILOAD:
                            if (idx_bad) st_reg <= ST_INDEX;
                            else if (sp_reg >= SPW'(STACK_DEPTH)) st_reg <= ST_OVER;
                            else res_reg <= lrd_reg;
                        OP_ISTORE:
                            if (idx_bad) st_reg <= ST_INDEX;
                            else if (sp_reg == '0) st_reg <= ST_UNDER;
                        OP_BIPUSH:
                            if (sp_reg >= SPW'(STACK_DEPTH)) st_reg <= ST_OVER;
                            else res_reg <= {{24{arg_reg[7]}}, arg_reg};
                        OP_DUP:
                            if (sp_reg == '0) st_reg <= ST_UNDER;
                            else if (sp_reg >= SPW'(STACK_DEPTH)) st_reg <= ST_OVER;
                            else res_reg <= srd_reg;
                        OP_INEG:
                            if (sp_reg == '0) st_reg <= ST_UNDER;
                            else res_reg <= 32'd0 - srd_reg;
                        default:
                            if (!binop) st_reg <= ST_ILL;
                            else if (sp_reg < SPW'(2)) st_reg <= ST_UNDER;
                            else
                            begin
                                case (op_reg)
                                    OP_IADD: res_reg <= a_reg + srd_reg;
                                    OP_ISUB: res_reg <= a_reg - srd_reg;
                                    OP_IMUL: res_reg <= a_reg * srd_reg;
                                    OP_IAND: res_reg <= a_reg & srd_reg;
                                    OP_IOR:  res_reg <= a_reg | srd_reg;
                                    OP_IXOR: res_reg <= a_reg ^ srd_reg;
                                    default:
                                        if (srd_reg == '0) st_reg <= ST_DIVZ;
                                        else
                                        begin
                                            dvd_reg   <= a_reg[31] ? 32'd0 - a_reg : a_reg;
                                            dvs_reg   <= srd_reg[31] ? 32'd0 - srd_reg
                                                                     : srd_reg;
                                            qneg_reg  <= a_reg[31] ^ srd_reg[31];
                                            rneg_reg  <= a_reg[31];
                                            rem_reg   <= '0;
                                            quo_reg   <= '0;
                                            cnt_reg   <= '0;
                                            state_reg <= S_DIV;
                                        end
                                endcase
                            end
                    endcase
                end
                S_DIV:
                begin
                    dvd_reg <= {dvd_reg[30:0], 1'b0};
                    if (!trial[32])
                    begin
                        rem_reg <= trial[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[30:0], dvd_reg[31]};
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd31)
                        state_reg <= S_TOP2;
                end
                S_TOP2:
                begin
                    if (op_reg == OP_IDIV)
                        res_reg <= qneg_reg ? 32'd0 - quo_reg : quo_reg;
                    else
                        res_reg <= rneg_reg ? 32'd0 - rem_reg : rem_reg;
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    if (st_reg == ST_OK)
                    begin
                        case (op_reg)
                            OP_ILOAD, OP_BIPUSH, OP_DUP: sp_reg <= sp_reg + 1'b1;
                            OP_INEG: sp_reg <= sp_reg;
                            default: sp_reg <= sp_reg - 1'b1;
                        endcase
                    end
                    state_reg <= S_TOP;
                end
                S_TOP:
                    state_reg <= S_OUT;
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign status      = st_reg;
    assign top_value   = (sp_reg == '0) ? 32'sd0 : $signed(srd_reg);
    assign stack_count = 7'(sp_reg);
endmodule
`default_nettype wire

/* test/tb_jvm_int_stack_executor.sv */
// Testbench: integer bytecode executor checked against a behavioral stack machine.
`default_nettype none
module tb_jvm_int_stack_executor;
    import jise_pkg::*;

    localparam int DEPTH  = STACK_DEPTH_DEF;
    localparam int NLOCAL = LOCAL_COUNT_DEF;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] top;
        logic [6:0]  cnt;
    } result_t;

    typedef struct {
        logic [7:0] op;
        logic [7:0] arg;
        bit         fixed;
        result_t    want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  opcode;
    logic [7:0]  operand_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic signed [31:0] top_value;
    logic [6:0]  stack_count;

    logic [31:0] model_stack [DEPTH];
    int          model_sp;
    logic [31:0] model_locals [NLOCAL];
    result_t     pending_results[$];
    int          errors;
    int          in_idle_pct;
    int          out_idle_pct;
    row_t        rows[$];

    jvm_int_stack_executor dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .operand_byte(operand_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .top_value(top_value), .stack_count(stack_count)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #200_000_000;
        $display("jvm_int_stack_executor verification failed");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [2:0] run_bytecode(input logic [7:0] op, input logic [7:0] arg);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        case (op)
            OP_ILOAD, OP_ISTORE:
            begin
                if (int'(arg) >= NLOCAL) return ST_INDEX;
                if (op == OP_ILOAD)
                begin
                    if (model_sp >= DEPTH) return ST_OVER;
                    model_stack[model_sp] = model_locals[arg];
                    model_sp++;
                end
                else
                begin
                    if (model_sp < 1) return ST_UNDER;
                    model_locals[arg] = model_stack[model_sp-1];
                    model_sp--;
                end
                return ST_OK;
            end
            OP_BIPUSH:
            begin
                if (model_sp >= DEPTH) return ST_OVER;
                model_stack[model_sp] = {{24{arg[7]}}, arg};
                model_sp++;
                return ST_OK;
            end
            OP_DUP:
            begin
                if (model_sp < 1) return ST_UNDER;
                if (model_sp >= DEPTH) return ST_OVER;
                model_stack[model_sp] = model_stack[model_sp-1];
                model_sp++;
                return ST_OK;
            end
            OP_INEG:
            begin
                if (model_sp < 1) return ST_UNDER;
                model_stack[model_sp-1] = 32'd0 - model_stack[model_sp-1];
                return ST_OK;
            end
            OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM, OP_IAND, OP_IOR, OP_IXOR:
            begin
                if (model_sp < 2) return ST_UNDER;
                a = model_stack[model_sp-2];
                b = model_stack[model_sp-1];
                if ((op == OP_IDIV || op == OP_IREM) && b == 0) return ST_DIVZ;
                case (op)
                    OP_IADD: r = a + b;
                    OP_ISUB: r = a - b;
                    OP_IMUL: r = a * b;
                    OP_IDIV: r = (a == 32'h8000_0000 && b == '1) ? a
                                 : 32'($signed(a) / $signed(b));
                    OP_IREM: r = (a == 32'h8000_0000 && b == '1) ? 32'd0
                                 : 32'($signed(a) % $signed(b));
                    OP_IAND: r = a & b;
                    OP_IOR:  r = a | b;
                    default: r = a ^ b;
                endcase
                model_stack[model_sp-2] = r;
                model_sp--;
                return ST_OK;
            end
            default: return ST_ILL;
        endcase
    endfunction

    function automatic result_t predict_result(input logic [7:0] op, input logic [7:0] arg);
        result_t res;
        res.st  = run_bytecode(op, arg);
        res.top = (model_sp > 0) ? model_stack[model_sp-1] : 32'd0;
        res.cnt = 7'(model_sp);
        return res;
    endfunction

    task automatic send(input logic [7:0] op, input logic [7:0] arg,
                        input bit fixed, input result_t want);
        result_t exp_res;
        if (($urandom_range(99)) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (($urandom_range(99)) < in_idle_pct);
        end
        exp_res = predict_result(op, arg);
        if (fixed && exp_res != want)
            report("table entry", 32'(exp_res), 32'(want));
        pending_results.push_back(exp_res);
        in_valid     <= 1'b1;
        opcode       <= op;
        operand_byte <= arg;
        do @(posedge clk); while (!in_ready);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected transfer at %0t", $realtime);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (status !== exp_res.st) report("status", 32'(status), 32'(exp_res.st));
                if (top_value !== exp_res.top) report("top_value", top_value, exp_res.top);
                if (stack_count !== exp_res.cnt)
                    report("stack_count", 32'(stack_count), 32'(exp_res.cnt));
            end
        end
    end

    function automatic logic [7:0] pick_opcode(input int depth_hint);
        logic [7:0] ops [13] = '{OP_ILOAD, OP_BIPUSH, OP_ISTORE, OP_DUP, OP_IADD, OP_ISUB,
                                 OP_IMUL, OP_IDIV, OP_IREM, OP_INEG, OP_IAND, OP_IOR, OP_IXOR};
        int sel;
        sel = $urandom_range(99);
        if (sel < 4) return 8'($urandom);
        if (depth_hint < 3 && sel < 50) return ($urandom_range(1)) ? OP_BIPUSH : OP_ILOAD;
        if (depth_hint > DEPTH - 3 && sel < 50) return OP_IADD;
        return ops[$urandom_range(12)];
    endfunction

    function automatic logic [7:0] pick_arg();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_row(input logic [7:0] op, input logic [7:0] arg,
                                    input bit fixed, input logic [2:0] st,
                                    input logic [31:0] top, input int cnt);
        row_t r;
        r.op = op; r.arg = arg; r.fixed = fixed;
        r.want = '{st: st, top: top, cnt: 7'(cnt)};
        rows.push_back(r);
    endfunction

    initial
    begin
        logic [7:0] op;
        errors = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = '0;
        operand_byte = '0;
        out_ready = 1'b0;
        in_idle_pct = 19;
        out_idle_pct = 47;
        foreach (model_stack[i]) model_stack[i] = '0;
        foreach (model_locals[i]) model_locals[i] = '0;
        model_sp = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        add_row(OP_IADD,   8'h00, 1, ST_UNDER, 32'd0, 0);
        add_row(OP_ISTORE, 8'h05, 1, ST_UNDER, 32'd0, 0);
        add_row(OP_DUP,    8'h00, 1, ST_UNDER, 32'd0, 0);
        add_row(OP_INEG,   8'h00, 1, ST_UNDER, 32'd0, 0);
        add_row(8'hFF,     8'h00, 1, ST_ILL,   32'd0, 0);
        add_row(OP_ILOAD,  8'hFF, 1, ST_OK,    32'd0, 1);
        add_row(OP_BIPUSH, 8'h80, 1, ST_OK,    32'hFFFF_FF80, 2);
        add_row(OP_BIPUSH, 8'h7F, 1, ST_OK,    32'h7F, 3);
        add_row(OP_IMUL,   8'h00, 0, ST_OK, 0, 0);
        add_row(OP_BIPUSH, 8'h00, 1, ST_OK,    32'd0, 3);
        add_row(OP_IDIV,   8'h00, 1, ST_DIVZ,  32'd0, 3);
        add_row(OP_IREM,   8'h00, 1, ST_DIVZ,  32'd0, 3);
        add_row(OP_ISUB,   8'h00, 0, ST_OK, 0, 0);
        add_row(OP_BIPUSH, 8'h01, 0, ST_OK, 0, 0);
        add_row(OP_ISUB,   8'h00, 0, ST_OK, 0, 0);
        add_row(OP_BIPUSH, 8'hFF, 0, ST_OK, 0, 0);
        add_row(OP_DUP,    8'h00, 0, ST_OK, 0, 0);
        add_row(OP_IAND,   8'h00, 0, ST_OK, 0, 0);
        add_row(OP_IOR,    8'h00, 0, ST_OK, 0, 0);
        add_row(OP_IXOR,   8'h00, 0, ST_OK, 0, 0);
        add_row(OP_INEG,   8'h00, 0, ST_OK, 0, 0);
        add_row(OP_ISTORE, 8'h00, 0, ST_OK, 0, 0);
        foreach (rows[i]) send(rows[i].op, rows[i].arg, rows[i].fixed, rows[i].want);

        // minimum over minus one, for both division ops
        for (int k = 0; k < 2; k++)
        begin
            send(OP_BIPUSH, 8'h01, 0, '0);
            for (int s = 0; s < 31; s++)
            begin
                send(OP_DUP, 8'h00, 0, '0);
                send(OP_IADD, 8'h00, 0, '0);
            end
            send(OP_BIPUSH, 8'hFF, 0, '0);
            send(k ? OP_IREM : OP_IDIV, 8'h00, 0, '0);
            send(OP_ISTORE, 8'($urandom), 0, '0);
        end
        // fill to overflow then drain
        while (model_sp < DEPTH) send(OP_BIPUSH, 8'($urandom), 0, '0);
        send(OP_BIPUSH, 8'h01, 0, '0);
        send(OP_ILOAD, 8'h00, 0, '0);
        send(OP_DUP, 8'h00, 0, '0);
        while (model_sp > 0) send(OP_ISTORE, 8'($urandom), 0, '0);

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        for (int phase = 0; phase < 3; phase++)
        begin
            in_idle_pct  = (phase == 0) ? 19 : (phase == 1) ? 47 : 0;
            out_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 19 : 0;
            for (int n = 0; n < 90; n++)
            begin
                op = pick_opcode(model_sp);
                send(op, pick_arg(), 0, '0);
                if (n == 45)
                begin
                    in_valid <= 1'b0;
                    wait (pending_results.size() == 0);
                end
            end
        end

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("jvm_int_stack_executor verification clean");
        else
            $display("jvm_int_stack_executor verification failed");
        $finish;
    end
endmodule
`default_nettype wire
